/* sv/dik_pkg.sv */
// ----------------------------------------------------------------------------
// dik_pkg: shared types and constants for the delta inverse kinematics block
// Holds the fixed-point constants, status codes, register indexes and the
// structs that travel between the front, the queue and the back.
// ----------------------------------------------------------------------------
package dik_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int PROD_SHIFT = 2 * FRAC_BITS;

  // sin 60 in Q30, split in two 15-bit halves for narrow multipliers
  localparam logic [14:0] SIN60_HI = 15'd28377;
  localparam logic [14:0] SIN60_LO = 15'd30161;

  localparam logic [41:0] ROUND_HALF = 42'(1) << (PROD_SHIFT - 1);
  localparam logic [41:0] STEP_MAX   = 42'h0007FFFFFFF;

  // radix-4 root: two result bits per cycle over a 40-bit radicand
  localparam logic [3:0] ROOT_CYCLES = 4'd10;

  localparam logic [2:0] REG_TOWER_RADIUS     = 3'd0;
  localparam logic [2:0] REG_ROD_LENGTH       = 3'd1;
  localparam logic [2:0] REG_MAX_HEIGHT       = 3'd2;
  localparam logic [2:0] REG_PRINTABLE_RADIUS = 3'd3;
  localparam logic [2:0] REG_STEPS_PER_MM     = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SOFT  = 2'd1,
    ST_REACH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_SCALE,
    BK_DONE
  } back_state_t;

  // configuration and the values derived from it
  typedef struct packed {
    logic [19:0] radius;
    logic [19:0] tx;
    logic [39:0] rod2;
    logic [39:0] pr2;
    logic [19:0] max_height;
    logic [19:0] step_scale;
  } cfg_t;

  // one classified point waiting for the back
  typedef struct packed {
    status_t            status;
    logic signed [19:0] z;
    logic [39:0]        rad_a;
    logic [39:0]        rad_b;
    logic [39:0]        rad_c;
  } qent_t;

endpackage

/* sv/delta_inverse_kinematics_steps.sv */
// ----------------------------------------------------------------------------
// delta_inverse_kinematics_steps: delta robot point to carriage step counts
// Classifies a Cartesian point, then takes three rounded roots and scales.
// ----------------------------------------------------------------------------
// Path: an input word runs through the front stages, a queue write and pop,
//   the root iterations, height, scale and the output register.
// The back sequencer takes one point at a time and pops no new point until
//   the last is handed to the output register; rejected points skip the roots.
// Reset: rst is synchronous, active high; it empties the pipe and the queue
//   and loads every configuration register with its default.
module delta_inverse_kinematics_steps import dik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // x_pos[19:0], y_pos[39:20], z_pos[59:40], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // steps_a[30:0], steps_b[61:31], steps_c[92:62], pad
  output logic [1:0]  m_tuser,  // status[1:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [19:0] tower_radius, rod_length, max_height, printable_radius, step_scale;
  logic [34:0] tx_hi, tx_lo;
  logic [50:0] tx_sum;
  logic [19:0] tx;
  logic [39:0] rod2, pr2;
  cfg_t        cfg;

  logic  fq_valid, fq_ready, bq_valid, bq_ready;
  qent_t fq_data, bq_data;

  // register file; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      tower_radius     <= 20'd25600;
      rod_length       <= 20'd64000;
      max_height       <= 20'd76800;
      printable_radius <= 20'd23040;
      step_scale       <= 20'd20480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOWER_RADIUS:     tower_radius     <= cfg_data;
        REG_ROD_LENGTH:       rod_length       <= cfg_data;
        REG_MAX_HEIGHT:       max_height       <= cfg_data;
        REG_PRINTABLE_RADIUS: printable_radius <= cfg_data;
        REG_STEPS_PER_MM:     step_scale       <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived geometry: tower x offset in two stages, squared rod and radius.
  // The front first reads tx in its third stage, after both stages settle.
  assign tx_sum = {1'b0, tx_hi, 15'b0} + {16'b0, tx_lo} + (51'(1) << 29);

  always_ff @(posedge clk) begin
    tx_hi <= tower_radius * SIN60_HI;
    tx_lo <= tower_radius * SIN60_LO;
    tx    <= tx_sum[49:30];
    rod2  <= rod_length * rod_length;
    pr2   <= printable_radius * printable_radius;
  end

  always_comb begin
    cfg.radius     = tower_radius;
    cfg.tx         = tx;
    cfg.rod2       = rod2;
    cfg.pr2        = pr2;
    cfg.max_height = max_height;
    cfg.step_scale = step_scale;
  end

  // front: accept and classify words
  dik_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // queue: hold classified points while the back works
  dik_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  // back: roots, heights, step scaling and the output register
  dik_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_data     (bq_data),
    .step_scale (cfg.step_scale),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

/* sv/dik_front.sv */
// ----------------------------------------------------------------------------
// dik_front: point intake and classification
// Five-stage pipeline: soft bounds check and the three rod radicands.
// ----------------------------------------------------------------------------
module dik_front import dik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  input  cfg_t        cfg,
  output logic        q_valid,
  input  logic        q_ready,
  output qent_t       q_data
);

  logic en;

  logic v0, v1, v2, v3, v4;
  logic signed [19:0] x0, y0, z0, x1, y1, z1, z2, z3;
  logic [39:0] xx1, yy1;
  logic soft2, soft3;
  logic signed [21:0] dx2 [3];
  logic signed [21:0] dy2 [3];
  logic [41:0] dxx3 [3];
  logic [41:0] dyy3 [3];
  qent_t ent4;

  logic signed [39:0] xs, ys;
  logic signed [21:0] px [3];
  logic signed [21:0] py [3];
  logic signed [43:0] dxs [3];
  logic signed [43:0] dys [3];
  logic signed [44:0] ins [3];
  logic [2:0] reach_ok;

  // advance the whole pipe unless the last stage is blocked
  assign en       = !(v4 && !q_ready);
  assign s_tready = en;
  assign q_valid  = v4;
  assign q_data   = ent4;

  assign xs = x0 * x0;
  assign ys = y0 * y0;

  always_comb begin
    px[0] = -$signed({2'b00, cfg.tx});
    px[1] = $signed({2'b00, cfg.tx});
    px[2] = '0;
    py[0] = -$signed({3'b000, cfg.radius[19:1]});
    py[1] = -$signed({3'b000, cfg.radius[19:1]});
    py[2] = $signed({2'b00, cfg.radius});
    for (int k = 0; k < 3; k++) begin
      dxs[k] = dx2[k] * dx2[k];
      dys[k] = dy2[k] * dy2[k];
      ins[k] = $signed({5'b0, cfg.rod2}) - $signed({3'b0, dxx3[k]})
               - $signed({3'b0, dyy3[k]});
      reach_ok[k] = !ins[k][44] && (ins[k] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= $signed(s_tdata[19:0]);
      y0 <= $signed(s_tdata[39:20]);
      z0 <= $signed(s_tdata[59:40]);

      xx1 <= 40'(xs);
      yy1 <= 40'(ys);
      x1  <= x0;
      y1  <= y0;
      z1  <= z0;

      soft2 <= z1[19] ||
               ($signed({z1[19], z1}) > $signed({1'b0, cfg.max_height})) ||
               (({1'b0, xx1} + {1'b0, yy1}) > {1'b0, cfg.pr2});
      for (int k = 0; k < 3; k++) begin
        dx2[k] <= px[k] - 22'(x1);
        dy2[k] <= py[k] - 22'(y1);
      end
      z2 <= z1;

      for (int k = 0; k < 3; k++) begin
        dxx3[k] <= dxs[k][41:0];
        dyy3[k] <= dys[k][41:0];
      end
      soft3 <= soft2;
      z3    <= z2;

      priority if (soft3) begin
        ent4.status <= ST_SOFT;
      end else if (reach_ok != 3'b111) begin
        ent4.status <= ST_REACH;
      end else begin
        ent4.status <= ST_OK;
      end
      ent4.z     <= z3;
      ent4.rad_a <= ins[0][39:0];
      ent4.rad_b <= ins[1][39:0];
      ent4.rad_c <= ins[2][39:0];
    end
  end

endmodule

/* sv/dik_fifo.sv */
// ----------------------------------------------------------------------------
// dik_fifo: four-entry queue between front and back
// Decouples the classification pipe from the root and scale sequencer.
// ----------------------------------------------------------------------------
module dik_fifo import dik_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  qent_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output qent_t out_data
);

  qent_t       mem [4];
  logic [1:0]  wptr, rptr;
  logic [2:0]  count;
  logic        push, pop;

  assign in_ready  = (count != 3'd4);
  assign out_valid = (count != 3'd0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop)  rptr <= rptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_data;
  end

endmodule

/* sv/dik_sqrt.sv */
// ----------------------------------------------------------------------------
// dik_sqrt: iterative rounded square root
// Two result bits per cycle over a 40-bit radicand; root rounded to nearest.
// ----------------------------------------------------------------------------
module dik_sqrt import dik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] radicand,
  output logic        done,
  output logic [20:0] root
);

  logic [39:0] nsh;
  logic [21:0] rem;
  logic [19:0] q;
  logic [3:0]  cnt;
  logic        busy;

  logic [23:0] rs1, rs2, tr1, tr2;
  logic [21:0] rem1, rem2;
  logic [19:0] q1, q2;

  always_comb begin
    rs1 = {rem, nsh[39:38]};
    tr1 = {2'b00, q, 2'b01};
    if (rs1 >= tr1) begin
      rem1 = 22'(rs1 - tr1);
      q1   = {q[18:0], 1'b1};
    end else begin
      rem1 = rs1[21:0];
      q1   = {q[18:0], 1'b0};
    end
    rs2 = {rem1, nsh[37:36]};
    tr2 = {2'b00, q1, 2'b01};
    if (rs2 >= tr2) begin
      rem2 = 22'(rs2 - tr2);
      q2   = {q1[18:0], 1'b1};
    end else begin
      rem2 = rs2[21:0];
      q2   = {q1[18:0], 1'b0};
    end
  end

  // round up when the remainder exceeds the floor root
  assign root = {1'b0, q} + {20'b0, (rem > {2'b00, q})};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ROOT_CYCLES;
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= radicand;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      nsh <= {nsh[35:0], 4'b0};
      rem <= rem2;
      q   <= q2;
    end
  end

endmodule

/* sv/dik_back.sv */
// ----------------------------------------------------------------------------
// dik_back: root, height and step scaling sequencer with output register
// Pops one classified point; an OK point gets three roots in lockstep and is scaled to steps, others zero steps.
// ----------------------------------------------------------------------------
module dik_back import dik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  qent_t       q_data,
  input  logic [19:0] step_scale,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,
  output logic [1:0]  m_tuser
);

  back_state_t state, state_next;

  status_t            status;
  logic signed [19:0] z;
  logic [20:0]        height [3];
  logic [40:0]        prod   [3];
  logic               start;
  logic [2:0]         done;
  logic [20:0]        root   [3];
  logic [39:0]        rad    [3];
  logic               out_free;
  logic [41:0]        rsum   [3];
  logic [41:0]        rsh    [3];
  logic [30:0]        steps  [3];

  assign rad[0] = q_data.rad_a;
  assign rad[1] = q_data.rad_b;
  assign rad[2] = q_data.rad_c;

  assign out_free = !m_tvalid || m_tready;

  for (genvar k = 0; k < 3; k++) begin : g_root
    dik_sqrt u_sqrt (
      .clk      (clk),
      .rst      (rst),
      .start    (start),
      .radicand (rad[k]),
      .done     (done[k]),
      .root     (root[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k] = {1'b0, prod[k]} + ROUND_HALF;
      rsh[k]  = rsum[k] >> PROD_SHIFT;
      if (status != ST_OK) begin
        steps[k] = '0;
      end else if (rsh[k] > STEP_MAX) begin
        steps[k] = STEP_MAX[30:0];
      end else begin
        steps[k] = rsh[k][30:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    start      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_data.status == ST_OK) begin
            start      = 1'b1;
            state_next = BK_ROOT;
          end else begin
            state_next = BK_DONE;
          end
        end
      end
      BK_ROOT: begin
        if (done[0]) state_next = BK_SCALE;
      end
      BK_SCALE: begin
        state_next = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_valid) begin
      status <= q_data.status;
      z      <= q_data.z;
    end
    if (state == BK_ROOT && done[0]) begin
      for (int k = 0; k < 3; k++) begin
        height[k] <= {1'b0, z[19:0]} + root[k];
      end
    end
    if (state == BK_SCALE) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= height[k] * step_scale;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == BK_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_DONE && out_free) begin
      m_tdata <= {3'b000, steps[2], steps[1], steps[0]};
      m_tuser <= status;
    end
  end

endmodule

/* sv/dik_checker.sv */
// ----------------------------------------------------------------------------
// dik_checker: port-level checks for delta_inverse_kinematics_steps
// Watches the result stream for hold, status coding, reject zeroing and valid after reset.
// ----------------------------------------------------------------------------
module dik_checker import dik_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [19:0] cfg_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_REACH)
    else $error("undefined status code");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == 96'd0)
    else $error("rejected point carries steps");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind delta_inverse_kinematics_steps dik_checker u_dik_checker (.*);
